[rtl/gastar_pkg.sv]
package gastar_pkg;

  localparam int DEF_MAX_COLUMNS = 32;
  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_COST_BITS   = 24;

  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int OP_W       = 2;
  localparam int COORD_W    = 5;
  localparam int TCOST_W    = 12;
  localparam int STEP_IDX_W = 10;
  localparam int LEN_W      = 11;
  localparam int OUT_COST_W = 24;
  localparam int STATUS_W   = 2;

  localparam int SQRT2_Q8      = 362;
  localparam int DIAG_EXTRA_Q8 = 106;
  localparam int ROUND_Q8      = 128;
  localparam int DSTEP_W       = 13;
  localparam int PROD_W        = 21;
  localparam longint OUT_COST_MAX = 64'd16777215;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_FIND = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK      = 2'd0,
    RES_NO_PATH = 2'd1,
    RES_OUTSIDE = 2'd2,
    RES_BEYOND  = 2'd3
  } res_status_t;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_CAPTURE,
    DP_MAP_CLR,
    DP_LOAD,
    DP_RES_RANGE,
    DP_RES_BEYOND,
    DP_RES_NONE,
    DP_FIND_INIT,
    DP_FLAG_CLR,
    DP_SEED,
    DP_SCAN_INIT,
    DP_SCAN,
    DP_RES_NOPATH,
    DP_GOAL,
    DP_CLOSE,
    DP_NB_RD,
    DP_NB_MUL,
    DP_NB_UPD,
    DP_RB_STEP,
    DP_RB_MOVE,
    DP_RB_NEXT,
    DP_RD_ISSUE,
    DP_RD_DONE
  } dp_op_t;

  typedef enum logic [3:0] {
    S_MAP_CLR,
    S_IDLE,
    S_DECODE,
    S_FLAG_CLR,
    S_SEED,
    S_SCAN_INIT,
    S_SCAN,
    S_NB_RD,
    S_NB_MUL,
    S_NB_UPD,
    S_RB_STEP,
    S_RB_MOVE,
    S_RB_NEXT,
    S_RD_DONE
  } fsm_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic find_oor;
    logic rd_beyond;
    logic clr_last;
    logic scan_done;
    logic found;
    logic at_goal;
    logic nb_last;
    logic rb_stop;
    logic rb_oob;
    logic rb_pass1;
  } dp_stat_t;

  // direction offsets as two-bit two's complement
  function automatic logic [1:0] dir_dx(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd0, 3'd4, 3'd5: r = 2'b01;
      3'd1, 3'd6, 3'd7: r = 2'b11;
      default:          r = 2'b00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dir_dy(input logic [2:0] d);
    logic [1:0] r;
    case (d)
      3'd2, 3'd4, 3'd6: r = 2'b01;
      3'd3, 3'd5, 3'd7: r = 2'b11;
      default:          r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

[rtl/gastar_ctrl.sv]
module gastar_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  gastar_pkg::dp_stat_t stat,
  output gastar_pkg::dp_cmd_t  cmd
);

  gastar_pkg::fsm_t state;
  gastar_pkg::fsm_t state_next;
  logic             done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gastar_pkg::S_MAP_CLR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != gastar_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd.op     = gastar_pkg::DP_IDLE;
    case (state)
      gastar_pkg::S_MAP_CLR: begin
        cmd.op = gastar_pkg::DP_MAP_CLR;
        if (stat.clr_last) state_next = gastar_pkg::S_IDLE;
      end
      gastar_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = gastar_pkg::DP_CAPTURE;
          state_next = gastar_pkg::S_DECODE;
        end
      end
      gastar_pkg::S_DECODE: begin
        case (stat.op)
          gastar_pkg::OP_LOAD: begin
            cmd.op     = gastar_pkg::DP_LOAD;
            done_next  = 1'b1;
            state_next = gastar_pkg::S_IDLE;
          end
          gastar_pkg::OP_FIND: begin
            if (stat.find_oor) begin
              cmd.op     = gastar_pkg::DP_RES_RANGE;
              done_next  = 1'b1;
              state_next = gastar_pkg::S_IDLE;
            end else begin
              cmd.op     = gastar_pkg::DP_FIND_INIT;
              state_next = gastar_pkg::S_FLAG_CLR;
            end
          end
          gastar_pkg::OP_READ: begin
            if (stat.rd_beyond) begin
              cmd.op     = gastar_pkg::DP_RES_BEYOND;
              done_next  = 1'b1;
              state_next = gastar_pkg::S_IDLE;
            end else begin
              cmd.op     = gastar_pkg::DP_RD_ISSUE;
              state_next = gastar_pkg::S_RD_DONE;
            end
          end
          default: begin
            cmd.op     = gastar_pkg::DP_RES_NONE;
            done_next  = 1'b1;
            state_next = gastar_pkg::S_IDLE;
          end
        endcase
      end
      gastar_pkg::S_FLAG_CLR: begin
        cmd.op = gastar_pkg::DP_FLAG_CLR;
        if (stat.clr_last) state_next = gastar_pkg::S_SEED;
      end
      gastar_pkg::S_SEED: begin
        cmd.op     = gastar_pkg::DP_SEED;
        state_next = gastar_pkg::S_SCAN_INIT;
      end
      gastar_pkg::S_SCAN_INIT: begin
        cmd.op     = gastar_pkg::DP_SCAN_INIT;
        state_next = gastar_pkg::S_SCAN;
      end
      gastar_pkg::S_SCAN: begin
        cmd.op = gastar_pkg::DP_SCAN;
        if (stat.scan_done) begin
          if (!stat.found) begin
            cmd.op     = gastar_pkg::DP_RES_NOPATH;
            done_next  = 1'b1;
            state_next = gastar_pkg::S_IDLE;
          end else if (stat.at_goal) begin
            cmd.op     = gastar_pkg::DP_GOAL;
            state_next = gastar_pkg::S_RB_STEP;
          end else begin
            cmd.op     = gastar_pkg::DP_CLOSE;
            state_next = gastar_pkg::S_NB_RD;
          end
        end
      end
      gastar_pkg::S_NB_RD: begin
        cmd.op     = gastar_pkg::DP_NB_RD;
        state_next = gastar_pkg::S_NB_MUL;
      end
      gastar_pkg::S_NB_MUL: begin
        cmd.op     = gastar_pkg::DP_NB_MUL;
        state_next = gastar_pkg::S_NB_UPD;
      end
      gastar_pkg::S_NB_UPD: begin
        cmd.op     = gastar_pkg::DP_NB_UPD;
        state_next = stat.nb_last ? gastar_pkg::S_SCAN_INIT : gastar_pkg::S_NB_RD;
      end
      gastar_pkg::S_RB_STEP: begin
        cmd.op     = gastar_pkg::DP_RB_STEP;
        state_next = stat.rb_stop ? gastar_pkg::S_RB_NEXT : gastar_pkg::S_RB_MOVE;
      end
      gastar_pkg::S_RB_MOVE: begin
        cmd.op     = gastar_pkg::DP_RB_MOVE;
        state_next = stat.rb_oob ? gastar_pkg::S_RB_NEXT : gastar_pkg::S_RB_STEP;
      end
      gastar_pkg::S_RB_NEXT: begin
        cmd.op = gastar_pkg::DP_RB_NEXT;
        if (stat.rb_pass1) begin
          done_next  = 1'b1;
          state_next = gastar_pkg::S_IDLE;
        end else begin
          state_next = gastar_pkg::S_RB_STEP;
        end
      end
      gastar_pkg::S_RD_DONE: begin
        cmd.op     = gastar_pkg::DP_RD_DONE;
        done_next  = 1'b1;
        state_next = gastar_pkg::S_IDLE;
      end
      default: state_next = gastar_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/gastar_dp.sv]
module gastar_dp #(
  parameter int MAX_COLUMNS = gastar_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gastar_pkg::DEF_MAX_ROWS,
  parameter int COST_BITS   = gastar_pkg::DEF_COST_BITS,
  localparam int XW = $clog2(MAX_COLUMNS),
  localparam int YW = $clog2(MAX_ROWS)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gastar_pkg::dp_cmd_t                   cmd,
  output gastar_pkg::dp_stat_t                  stat,
  input  logic [XW:0]                          act_w,
  input  logic [YW:0]                          act_l,
  input  logic [gastar_pkg::OP_W-1:0]          operation,
  input  logic [gastar_pkg::COORD_W-1:0]       tile_x,
  input  logic [gastar_pkg::COORD_W-1:0]       tile_y,
  input  logic                                 walkable_bit,
  input  logic [gastar_pkg::TCOST_W-1:0]       tile_cost,
  input  logic [gastar_pkg::COORD_W-1:0]       target_x,
  input  logic [gastar_pkg::COORD_W-1:0]       target_y,
  input  logic [gastar_pkg::STEP_IDX_W-1:0]    step_index,
  output logic [gastar_pkg::STATUS_W-1:0]      status,
  output logic [gastar_pkg::LEN_W-1:0]         path_length,
  output logic [gastar_pkg::OUT_COST_W-1:0]    path_cost,
  output logic [gastar_pkg::COORD_W-1:0]       step_x,
  output logic [gastar_pkg::COORD_W-1:0]       step_y
);

  localparam int XW1   = XW + 1;
  localparam int YW1   = YW + 1;
  localparam int TILES = MAX_COLUMNS * MAX_ROWS;
  localparam int IDX_W = $clog2(TILES);
  localparam int CNT_W = $clog2(TILES + 1);
  localparam int CW0   = (XW > YW) ? XW : YW;
  localparam int HW    = CW0 + 9;
  localparam int FW    = ((COST_BITS > HW) ? COST_BITS : HW) + 1;
  localparam int PW0   = (CW0 > gastar_pkg::COORD_W) ? CW0 : gastar_pkg::COORD_W;
  localparam int CMPW  = PW0 + 1;
  localparam int KW    = (CNT_W > gastar_pkg::STEP_IDX_W) ? CNT_W : gastar_pkg::STEP_IDX_W;
  localparam int SATW  = (COST_BITS > gastar_pkg::OUT_COST_W) ? COST_BITS
                                                              : gastar_pkg::OUT_COST_W;
  localparam int MAPW  = gastar_pkg::TCOST_W + 1;
  localparam int SRW   = COST_BITS + 5;
  localparam int PTW   = XW + YW;
  localparam int DW    = gastar_pkg::DSTEP_W;
  localparam int MW    = gastar_pkg::PROD_W;

  function automatic logic [IDX_W-1:0] tidx(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return IDX_W'(y) * IDX_W'(MAX_COLUMNS) + IDX_W'(x);
  endfunction

  function automatic logic [HW-1:0] octile(input logic [XW-1:0] x, input logic [YW-1:0] y,
                                          input logic [XW-1:0] tx, input logic [YW-1:0] ty);
    logic [XW-1:0]  dx;
    logic [YW-1:0]  dy;
    logic [CW0-1:0] ex;
    logic [CW0-1:0] ey;
    logic [CW0-1:0] hi;
    logic [CW0-1:0] lo;
    dx = (x > tx) ? x - tx : tx - x;
    dy = (y > ty) ? y - ty : ty - y;
    ex = CW0'(dx);
    ey = CW0'(dy);
    hi = (ex > ey) ? ex : ey;
    lo = (ex > ey) ? ey : ex;
    return (HW'(hi) << 8) + HW'(lo) * HW'(gastar_pkg::DIAG_EXTRA_Q8);
  endfunction

  // captured request
  gastar_pkg::op_t                  c_op;
  logic [gastar_pkg::COORD_W-1:0]   c_x, c_y, c_tx, c_ty;
  logic                             c_walk;
  logic [gastar_pkg::TCOST_W-1:0]   c_cost;
  logic [gastar_pkg::STEP_IDX_W-1:0] c_k;

  logic [XW-1:0] sx, tx_c;
  logic [YW-1:0] sy, ty_c;
  logic          load_oor, tgt_oor;

  logic [IDX_W-1:0] clr_cnt;
  logic             clr_last;

  // scan
  logic [XW-1:0]    scan_x, sv_x, bx;
  logic [YW-1:0]    scan_y, sv_y, by;
  logic             scan_run, sv_valid, scan_last, bfound;
  logic [FW-1:0]    bf, cur_f;
  logic [COST_BITS-1:0] bg;
  logic [2:0]       bpar;
  logic [XW:0]      aw_m1;
  logic [YW:0]      al_m1;

  // neighbors
  logic [2:0]       nb_d;
  logic [XW:0]      nx_w;
  logic [YW:0]      ny_w;
  logic             nb_in, nb_in_r, nb_ok, nb_open, nb_upd;
  logic [IDX_W-1:0] nb_addr, nb_idx;
  logic [DW-1:0]    step_r;
  logic [MW-1:0]    prod;
  logic [COST_BITS-1:0] nb_g, ng;
  logic [COST_BITS:0]   nsum;

  // rebuild
  logic [XW-1:0]    rb_x;
  logic [YW-1:0]    rb_y;
  logic [CNT_W-1:0] rb_cnt, rb_k, k_dec;
  logic             rb_pass;
  logic [XW:0]      rx_w;
  logic [YW:0]      ry_w;

  logic [CNT_W-1:0] path_count;
  logic [gastar_pkg::OUT_COST_W-1:0] kept_cost;
  logic [gastar_pkg::OUT_COST_W-1:0] bg_sat;

  // memories
  logic [MAPW-1:0]  map_mem [TILES];
  logic [SRW-1:0]   srch_mem [TILES];
  logic [PTW-1:0]   path_mem [TILES];
  logic             map_we, srch_we, path_we;
  logic [IDX_W-1:0] map_waddr, map_raddr, srch_waddr, srch_raddr, path_waddr, path_raddr;
  logic [MAPW-1:0]  map_wdata, map_rd;
  logic [SRW-1:0]   srch_wdata, srch_rd;
  logic [PTW-1:0]   path_wdata, path_rd;

  logic                 sr_open, sr_closed;
  logic [2:0]           sr_par;
  logic [COST_BITS-1:0] sr_g;

  assign sr_open   = srch_rd[SRW-1];
  assign sr_closed = srch_rd[SRW-2];
  assign sr_par    = srch_rd[COST_BITS +: 3];
  assign sr_g      = srch_rd[COST_BITS-1:0];

  assign sx   = XW'(c_x);
  assign sy   = YW'(c_y);
  assign tx_c = XW'(c_tx);
  assign ty_c = YW'(c_ty);

  assign load_oor = (CMPW'(c_x) >= CMPW'(act_w)) || (CMPW'(c_y) >= CMPW'(act_l));
  assign tgt_oor  = (CMPW'(c_tx) >= CMPW'(act_w)) || (CMPW'(c_ty) >= CMPW'(act_l));
  assign clr_last = (clr_cnt == IDX_W'(TILES - 1));

  assign aw_m1     = act_w - XW1'(1);
  assign al_m1     = act_l - YW1'(1);
  assign scan_last = ({1'b0, scan_x} == aw_m1) && ({1'b0, scan_y} == al_m1);
  assign cur_f     = FW'(sr_g) + FW'(octile(sv_x, sv_y, tx_c, ty_c));

  assign nx_w    = {1'b0, bx} + XW1'($signed(gastar_pkg::dir_dx(nb_d)));
  assign ny_w    = {1'b0, by} + YW1'($signed(gastar_pkg::dir_dy(nb_d)));
  assign nb_in   = (nx_w < act_w) && (ny_w < act_l);
  assign nb_addr = tidx(nx_w[XW-1:0], ny_w[YW-1:0]);
  // diagonal step is cost times sqrt2, rounded half up
  assign prod    = MW'(map_rd[gastar_pkg::TCOST_W-1:0]) * MW'(gastar_pkg::SQRT2_Q8)
                 + MW'(gastar_pkg::ROUND_Q8);
  assign nsum    = (COST_BITS+1)'(bg) + (COST_BITS+1)'(step_r);
  assign ng      = nsum[COST_BITS] ? {COST_BITS{1'b1}} : nsum[COST_BITS-1:0];
  assign nb_upd  = nb_ok && (!nb_open || (ng < nb_g));

  assign rx_w  = {1'b0, rb_x} - XW1'($signed(gastar_pkg::dir_dx(sr_par)));
  assign ry_w  = {1'b0, rb_y} - YW1'($signed(gastar_pkg::dir_dy(sr_par)));
  assign k_dec = rb_k - CNT_W'(1);

  assign bg_sat = (SATW'(bg) > SATW'(gastar_pkg::OUT_COST_MAX))
                ? {gastar_pkg::OUT_COST_W{1'b1}} : gastar_pkg::OUT_COST_W'(bg);

  always_comb begin
    stat.op        = c_op;
    stat.find_oor  = load_oor || tgt_oor;
    stat.rd_beyond = (KW'(c_k) >= KW'(path_count));
    stat.clr_last  = clr_last;
    stat.scan_done = !scan_run && !sv_valid;
    stat.found     = bfound;
    stat.at_goal   = (bx == tx_c) && (by == ty_c);
    stat.nb_last   = (nb_d == 3'd7);
    stat.rb_stop   = ((rb_x == sx) && (rb_y == sy)) || (rb_cnt >= CNT_W'(TILES - 1));
    stat.rb_oob    = !((rx_w < act_w) && (ry_w < act_l));
    stat.rb_pass1  = rb_pass;
  end

  // memory port steering
  always_comb begin
    map_we     = 1'b0;
    map_waddr  = '0;
    map_wdata  = '0;
    map_raddr  = '0;
    srch_we    = 1'b0;
    srch_waddr = '0;
    srch_wdata = '0;
    srch_raddr = '0;
    path_we    = 1'b0;
    path_waddr = '0;
    path_wdata = '0;
    path_raddr = '0;
    case (cmd.op)
      gastar_pkg::DP_MAP_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt;
      end
      gastar_pkg::DP_LOAD: begin
        map_we    = !load_oor;
        map_waddr = tidx(sx, sy);
        map_wdata = {c_walk, c_cost};
      end
      gastar_pkg::DP_FLAG_CLR: begin
        srch_we    = 1'b1;
        srch_waddr = clr_cnt;
      end
      gastar_pkg::DP_SEED: begin
        srch_we    = 1'b1;
        srch_waddr = tidx(sx, sy);
        srch_wdata = {1'b1, 1'b0, 3'd0, {COST_BITS{1'b0}}};
      end
      gastar_pkg::DP_SCAN: srch_raddr = tidx(scan_x, scan_y);
      gastar_pkg::DP_CLOSE: begin
        srch_we    = 1'b1;
        srch_waddr = tidx(bx, by);
        srch_wdata = {1'b0, 1'b1, bpar, bg};
      end
      gastar_pkg::DP_NB_RD: begin
        map_raddr  = nb_addr;
        srch_raddr = nb_addr;
      end
      gastar_pkg::DP_NB_UPD: begin
        srch_we    = nb_upd;
        srch_waddr = nb_idx;
        srch_wdata = {1'b1, 1'b0, nb_d, ng};
      end
      gastar_pkg::DP_RB_STEP: begin
        srch_raddr = tidx(rb_x, rb_y);
        path_we    = rb_pass && (rb_k != '0);
        path_waddr = k_dec[IDX_W-1:0];
        path_wdata = {rb_y, rb_x};
      end
      gastar_pkg::DP_RD_ISSUE: path_raddr = IDX_W'(c_k);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rd <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (srch_we) srch_mem[srch_waddr] <= srch_wdata;
    srch_rd <= srch_mem[srch_raddr];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_waddr] <= path_wdata;
    path_rd <= path_mem[path_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      scan_run   <= 1'b0;
      sv_valid   <= 1'b0;
      bfound     <= 1'b0;
      path_count <= '0;
      kept_cost  <= '0;
      rb_pass    <= 1'b0;
      nb_d       <= '0;
    end else begin
      case (cmd.op)
        gastar_pkg::DP_CAPTURE: begin
          c_op   <= gastar_pkg::op_t'(operation);
          c_x    <= tile_x;
          c_y    <= tile_y;
          c_walk <= walkable_bit;
          c_cost <= tile_cost;
          c_tx   <= target_x;
          c_ty   <= target_y;
          c_k    <= step_index;
        end
        gastar_pkg::DP_MAP_CLR, gastar_pkg::DP_FLAG_CLR: begin
          clr_cnt <= clr_last ? '0 : clr_cnt + IDX_W'(1);
        end
        gastar_pkg::DP_LOAD: begin
          status      <= load_oor ? gastar_pkg::RES_OUTSIDE : gastar_pkg::RES_OK;
          path_length <= '0;
          path_cost   <= '0;
          step_x      <= '0;
          step_y      <= '0;
        end
        gastar_pkg::DP_RES_RANGE: begin
          path_count  <= '0;
          kept_cost   <= '0;
          status      <= gastar_pkg::RES_OUTSIDE;
          path_length <= '0;
          path_cost   <= '0;
          step_x      <= '0;
          step_y      <= '0;
        end
        gastar_pkg::DP_RES_BEYOND: begin
          status      <= gastar_pkg::RES_BEYOND;
          path_length <= gastar_pkg::LEN_W'(path_count);
          path_cost   <= kept_cost;
          step_x      <= '0;
          step_y      <= '0;
        end
        gastar_pkg::DP_RES_NONE: begin
          status      <= gastar_pkg::RES_OK;
          path_length <= '0;
          path_cost   <= '0;
          step_x      <= '0;
          step_y      <= '0;
        end
        gastar_pkg::DP_FIND_INIT: begin
          path_count <= '0;
          kept_cost  <= '0;
          clr_cnt    <= '0;
        end
        gastar_pkg::DP_SCAN_INIT: begin
          scan_x   <= '0;
          scan_y   <= '0;
          scan_run <= 1'b1;
          sv_valid <= 1'b0;
          bfound   <= 1'b0;
        end
        gastar_pkg::DP_SCAN: begin
          sv_valid <= scan_run;
          sv_x     <= scan_x;
          sv_y     <= scan_y;
          if (scan_run) begin
            if (scan_last) begin
              scan_run <= 1'b0;
            end else if ({1'b0, scan_x} == aw_m1) begin
              scan_x <= '0;
              scan_y <= scan_y + YW'(1);
            end else begin
              scan_x <= scan_x + XW'(1);
            end
          end
          // strict compare keeps the lowest index on ties
          if (sv_valid && sr_open && (!bfound || (cur_f < bf))) begin
            bfound <= 1'b1;
            bf     <= cur_f;
            bx     <= sv_x;
            by     <= sv_y;
            bg     <= sr_g;
            bpar   <= sr_par;
          end
        end
        gastar_pkg::DP_RES_NOPATH: begin
          status      <= gastar_pkg::RES_NO_PATH;
          path_length <= '0;
          path_cost   <= '0;
          step_x      <= '0;
          step_y      <= '0;
        end
        gastar_pkg::DP_GOAL: begin
          kept_cost <= bg_sat;
          rb_pass   <= 1'b0;
          rb_x      <= tx_c;
          rb_y      <= ty_c;
          rb_cnt    <= '0;
          rb_k      <= '0;
        end
        gastar_pkg::DP_CLOSE: nb_d <= '0;
        gastar_pkg::DP_NB_RD: begin
          nb_in_r <= nb_in;
          nb_idx  <= nb_addr;
        end
        gastar_pkg::DP_NB_MUL: begin
          step_r  <= nb_d[2] ? prod[MW-1:8] : DW'(map_rd[gastar_pkg::TCOST_W-1:0]);
          nb_ok   <= nb_in_r && map_rd[MAPW-1] && !sr_closed;
          nb_open <= sr_open;
          nb_g    <= sr_g;
        end
        gastar_pkg::DP_NB_UPD: nb_d <= nb_d + 3'd1;
        gastar_pkg::DP_RB_STEP: begin
          rb_cnt <= rb_cnt + CNT_W'(1);
          if (rb_pass && (rb_k != '0)) rb_k <= k_dec;
        end
        gastar_pkg::DP_RB_MOVE: begin
          rb_x <= rx_w[XW-1:0];
          rb_y <= ry_w[YW-1:0];
        end
        gastar_pkg::DP_RB_NEXT: begin
          if (!rb_pass) begin
            // second walk writes the path backwards from its end
            rb_pass <= 1'b1;
            rb_x    <= tx_c;
            rb_y    <= ty_c;
            rb_cnt  <= '0;
            rb_k    <= rb_cnt;
          end else begin
            path_count  <= rb_cnt;
            status      <= gastar_pkg::RES_OK;
            path_length <= gastar_pkg::LEN_W'(rb_cnt);
            path_cost   <= kept_cost;
            step_x      <= '0;
            step_y      <= '0;
          end
        end
        gastar_pkg::DP_RD_DONE: begin
          status      <= gastar_pkg::RES_OK;
          path_length <= gastar_pkg::LEN_W'(path_count);
          path_cost   <= kept_cost;
          step_x      <= gastar_pkg::COORD_W'(path_rd[XW-1:0]);
          step_y      <= gastar_pkg::COORD_W'(path_rd[PTW-1:XW]);
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/grid_astar_path_search_core.sv]
// load_tile, unused operations and searches outside the grid: result after capture and decode;
// read_path also reads the path memory unless the index is beyond the path. find_path: a flag
// clear over all tiles, then per expansion one scan of the active grid (one search-memory read
// per cycle) and a read, multiply and update step for each of the eight neighbors, then a
// parent walk, twice. One operation at a time; done pulses for one cycle and results cannot
// be held off. Reset clears the tile map over all MAX_COLUMNS * MAX_ROWS tiles.
module grid_astar_path_search_core #(
  parameter int MAX_COLUMNS = gastar_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = gastar_pkg::DEF_MAX_ROWS,
  parameter int COST_BITS   = gastar_pkg::DEF_COST_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  output logic                                 done,
  input  logic                                 cfg_we,
  input  logic [gastar_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gastar_pkg::CFG_W-1:0]         cfg_data,
  input  logic [gastar_pkg::OP_W-1:0]          operation,
  input  logic [gastar_pkg::COORD_W-1:0]       tile_x,
  input  logic [gastar_pkg::COORD_W-1:0]       tile_y,
  input  logic                                 walkable_bit,
  input  logic [gastar_pkg::TCOST_W-1:0]       tile_cost,
  input  logic [gastar_pkg::COORD_W-1:0]       target_x,
  input  logic [gastar_pkg::COORD_W-1:0]       target_y,
  input  logic [gastar_pkg::STEP_IDX_W-1:0]    step_index,
  output logic [gastar_pkg::STATUS_W-1:0]      status,
  output logic [gastar_pkg::LEN_W-1:0]         path_length,
  output logic [gastar_pkg::OUT_COST_W-1:0]    path_cost,
  output logic [gastar_pkg::COORD_W-1:0]       step_x,
  output logic [gastar_pkg::COORD_W-1:0]       step_y
);

  localparam int XW   = $clog2(MAX_COLUMNS);
  localparam int YW   = $clog2(MAX_ROWS);
  localparam int XW1  = XW + 1;
  localparam int YW1  = YW + 1;
  localparam int GCW0 = (XW1 > gastar_pkg::CFG_W) ? XW1 : gastar_pkg::CFG_W;
  localparam int GCW1 = (YW1 > gastar_pkg::CFG_W) ? YW1 : gastar_pkg::CFG_W;
  localparam int GCW  = ((GCW0 > GCW1) ? GCW0 : GCW1) + 1;

  logic [gastar_pkg::CFG_W-1:0] grid_width;
  logic [gastar_pkg::CFG_W-1:0] grid_length;
  logic [XW:0]                  act_w;
  logic [YW:0]                  act_l;

  gastar_pkg::dp_cmd_t  cmd;
  gastar_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gastar_pkg::CFG_W'(32);
      grid_length <= gastar_pkg::CFG_W'(32);
    end else if (cfg_we) begin
      if (cfg_index == gastar_pkg::REG_GRID_WIDTH)  grid_width  <= cfg_data;
      if (cfg_index == gastar_pkg::REG_GRID_LENGTH) grid_length <= cfg_data;
    end
  end

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (grid_width == '0) act_w = XW1'(1);
    else if (GCW'(grid_width) > GCW'(MAX_COLUMNS)) act_w = XW1'(MAX_COLUMNS);
    else act_w = XW1'(grid_width);
    if (grid_length == '0) act_l = YW1'(1);
    else if (GCW'(grid_length) > GCW'(MAX_ROWS)) act_l = YW1'(MAX_ROWS);
    else act_l = YW1'(grid_length);
  end

  gastar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  gastar_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .COST_BITS   (COST_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .act_w        (act_w),
    .act_l        (act_l),
    .operation    (operation),
    .tile_x       (tile_x),
    .tile_y       (tile_y),
    .walkable_bit (walkable_bit),
    .tile_cost    (tile_cost),
    .target_x     (target_x),
    .target_y     (target_y),
    .step_index   (step_index),
    .status       (status),
    .path_length  (path_length),
    .path_cost    (path_cost),
    .step_x       (step_x),
    .step_y       (step_y)
  );

endmodule
